>>> rtl/box_blur_3x3_stream_macros.svh
// Assertion macros shared by the box blur RTL.
`ifndef BOX_BLUR_3X3_STREAM_MACROS_SVH
`define BOX_BLUR_3X3_STREAM_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BB3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bb3_pkg.sv
// Shared constants and types of the 3x3 box blur.
package bb3_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int ROW_W      = 12;
  localparam int NCH_W      = 3;
  localparam int SUM_W      = 12;

  localparam int DEF_MAX_WIDTH    = 2048;
  localparam int DEF_MAX_CHANNELS = 4;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH   = 12'd640;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT  = 12'd480;
  localparam logic [NCH_W-1:0]      RST_CHANNEL_COUNT = 3'd3;

  // floor(s/9) == (s*7282) >> 16 for all s < 4096
  localparam int DIV9_MUL_W = 13;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;
  localparam int DIV9_SHIFT = 16;

  // one channel's history: [row][age][bits], row 0 oldest line
  typedef logic [2:0][1:0][PIX_W-1:0] bb3_win_t;

  typedef struct packed {
    logic [PIX_W-1:0] val;
    logic             last;
  } bb3_res_t;

endpackage

>>> rtl/bb3_if.sv
// Stream and config channel interfaces of the 3x3 box blur.
interface bb3_in_if import bb3_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_sample;

  modport source (output valid, output pixel_sample, input ready);
  modport sink   (input valid, input pixel_sample, output ready);
endinterface

interface bb3_out_if import bb3_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blurred_sample;
  logic             frame_last;

  modport source (output valid, output blurred_sample, output frame_last, input ready);
  modport sink   (input valid, input blurred_sample, input frame_last, output ready);
endinterface

interface bb3_cfg_if import bb3_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/bb3_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module bb3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/box_blur_3x3_stream.sv
// Top level of the streaming 3x3 box blur over interleaved channel samples.
//
// Takes one 8-bit sample per beat in raster order, channels interleaved, and for every
// interior pixel (row and column both at least 2) returns floor(sum/9) of the 3x3
// neighbourhood centered one row up and one column left, in the same channel. Border
// samples give no result. frame_last marks the final result of a frame; the position
// counters wrap to zero after the last sample. Rate: one sample per clock unless a
// stalled consumer fills the output queue. Path: a line-store read (one registered RAM
// read), a window sum, then the divide-by-9 multiply into a two-entry output queue.
// in_bus.ready drops only while that queue is full, the consumer is stalling and a
// result waits in the sum stage, so one waiting result does not block input. The two
// previous lines live in one RAM of MAX_WIDTH*MAX_CHANNELS entries holding {older,
// newer} per address; each beat reads its entry and writes it back as it leaves stage
// 1. Two accesses to one address are at least a line apart, so no forwarding is needed.
// There is no clearing pass: line contents are undefined until a first frame fills
// them, which the interior rule never reads. Config is written on cfg_bus (always
// ready) only while idle, a user rule the block does not enforce. Registers:
// 0 image_width, 1 image_height, 2 channel_count, clamped to their legal ranges on use.
`include "box_blur_3x3_stream_macros.svh"

module box_blur_3x3_stream import bb3_pkg::*; #(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic          clk,
  input  logic          rst_n,
  bb3_in_if.sink        in_bus,
  bb3_out_if.source     out_bus,
  bb3_cfg_if.sink       cfg_bus
);

  localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CLW   = $clog2(MAX_WIDTH);
  localparam int EW    = (CLW + 1 > CFG_DATA_W) ? CLW + 1 : CFG_DATA_W;
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam logic [EW-1:0]    W_MAX = EW'(MAX_WIDTH);
  localparam logic [NCH_W-1:0] C_MAX = NCH_W'(MAX_CHANNELS);

  // ---------------- config registers ----------------
  logic [CFG_DATA_W-1:0] width_r;
  logic [ROW_W-1:0]      height_r;
  logic [NCH_W-1:0]      chans_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      chans_r  <= RST_CHANNEL_COUNT;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_IMAGE_WIDTH:   width_r  <= cfg_bus.data;
        REG_IMAGE_HEIGHT:  height_r <= cfg_bus.data;
        REG_CHANNEL_COUNT: chans_r  <= cfg_bus.data[NCH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective (clamped) geometry
  logic [EW-1:0]    w_ext, w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [NCH_W-1:0] n_eff;

  always_comb begin
    w_ext = EW'(width_r);
    if (w_ext < EW'(3))       w_eff = EW'(3);
    else if (w_ext > W_MAX)   w_eff = W_MAX;
    else                      w_eff = w_ext;
    h_eff = (height_r < ROW_W'(3)) ? ROW_W'(3) : height_r;
    if (chans_r == '0)        n_eff = NCH_W'(1);
    else if (chans_r > C_MAX) n_eff = C_MAX;
    else                      n_eff = chans_r;
  end

  // ---------------- stage 0: position counters, line read ----------------
  logic [CLW-1:0]   col_r, col_nxt, col_g;
  logic [ROW_W-1:0] row_r, row_nxt, row_g;
  logic [CHW-1:0]   ch_r, ch_nxt, ch_g;
  logic             last_ch, last_col, last_row;
  logic [AW-1:0]    addr;
  logic             adv, acc;

  always_comb begin
    col_g = (EW'(col_r) >= w_eff) ? CLW'(w_eff - EW'(1)) : col_r;
    row_g = (row_r >= h_eff) ? (h_eff - ROW_W'(1)) : row_r;
    ch_g  = (NCH_W'(ch_r) >= n_eff) ? CHW'(n_eff - NCH_W'(1)) : ch_r;

    last_ch  = (NCH_W'(ch_g) == n_eff - NCH_W'(1));
    last_col = (EW'(col_g) == w_eff - EW'(1));
    last_row = (row_g == h_eff - ROW_W'(1));

    addr = AW'(col_g) * AW'(MAX_CHANNELS) + AW'(ch_g);

    // channel, then column, then row; full wrap at end of frame
    if (!last_ch) begin
      ch_nxt  = ch_g + CHW'(1);
      col_nxt = col_g;
      row_nxt = row_g;
    end else begin
      ch_nxt = '0;
      if (!last_col) begin
        col_nxt = col_g + CLW'(1);
        row_nxt = row_g;
      end else begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_g + ROW_W'(1);
      end
    end
  end

  assign in_bus.ready = adv;
  assign acc          = in_bus.valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ch_r  <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ch_r  <= ch_nxt;
    end
  end

  // ---------------- stage 1: line data back, window sum, write-back ----------------
  logic             s1_v_r;
  logic [PIX_W-1:0] s1_x_r;
  logic [CHW-1:0]   s1_ch_r;
  logic [AW-1:0]    s1_addr_r;
  logic             s1_int_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_x_r    <= in_bus.pixel_sample;
      s1_ch_r   <= ch_g;
      s1_addr_r <= addr;
      s1_int_r  <= (row_g >= ROW_W'(2)) && (col_g >= CLW'(2));
      s1_last_r <= last_ch && last_col && last_row;
    end
  end

  // line RAM word: {older, newer}
  logic [2*PIX_W-1:0] line_rd;
  logic               line_wr_en;

  assign line_wr_en = s1_v_r && adv;

  bb3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (line_wr_en),
    .wr_addr (s1_addr_r),
    .wr_data ({line_rd[PIX_W-1:0], s1_x_r}),
    .rd_en   (acc),
    .rd_addr (addr),
    .rd_data (line_rd)
  );

  // per-channel window of the two previous columns
  bb3_win_t                 win_r [MAX_CHANNELS];
  bb3_win_t                 win_cur;
  logic [2:0][PIX_W-1:0]    column;
  logic [SUM_W-1:0]         sum;

  always_comb begin
    win_cur   = win_r[s1_ch_r];
    column[0] = line_rd[2*PIX_W-1:PIX_W];
    column[1] = line_rd[PIX_W-1:0];
    column[2] = s1_x_r;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      sum = sum + SUM_W'(column[k]) + SUM_W'(win_cur[k][0]) + SUM_W'(win_cur[k][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (line_wr_en) begin
      for (int k = 0; k < 3; k++) begin
        win_r[s1_ch_r][k][1] <= win_cur[k][0];
        win_r[s1_ch_r][k][0] <= column[k];
      end
    end
  end

  // ---------------- stage 2: sum register, divide by 9 ----------------
  logic             s2_res_r, s2_last_r;
  logic [SUM_W-1:0] s2_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_res_r <= 1'b0;
    end else if (adv) begin
      s2_res_r <= s1_v_r && s1_int_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sum_r  <= sum;
      s2_last_r <= s1_last_r;
    end
  end

  logic [SUM_W+DIV9_MUL_W-1:0] prod;
  bb3_res_t                    res;

  assign prod     = (SUM_W + DIV9_MUL_W)'(s2_sum_r) * (SUM_W + DIV9_MUL_W)'(DIV9_MUL);
  assign res.val  = prod[DIV9_SHIFT +: PIX_W];
  assign res.last = s2_last_r;

  // ---------------- output queue, two entries ----------------
  logic [1:0] cnt_r, cnt_nxt;
  bb3_res_t   q0_r, q1_r;
  logic       push, pop, wr_hi;

  assign pop  = (cnt_r != 2'd0) && out_bus.ready;
  assign adv  = !s2_res_r || (cnt_r != 2'd2) || out_bus.ready;
  assign push = adv && s2_res_r;

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    wr_hi   = (cnt_r == 2'd2) || ((cnt_r == 2'd1) && !pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // head takes the new result when it lands low, else shifts up on pop
  always_ff @(posedge clk) begin
    if (push && !wr_hi) begin
      q0_r <= res;
    end else if (pop) begin
      q0_r <= q1_r;
    end
    if (push && wr_hi) begin
      q1_r <= res;
    end
  end

  assign out_bus.valid          = (cnt_r != 2'd0);
  assign out_bus.blurred_sample = q0_r.val;
  assign out_bus.frame_last     = q0_r.last;

  // ---------------- assertions ----------------
  `BB3_ASSERT_NOW(a_q_no_overflow, push && (cnt_r == 2'd2), pop, "result pushed into full queue")
  `BB3_ASSERT_NEXT(a_s1_hold, s1_v_r && !adv, s1_v_r && $stable(s1_addr_r), "stage 1 beat lost on stall")
  `BB3_ASSERT_NOW(a_ram_no_collide, line_wr_en && acc, s1_addr_r != addr, "line RAM read and write hit one entry")
  `BB3_ASSERT_NEXT(a_frame_wrap, acc && last_ch && last_col && last_row, (row_r == '0) && (col_r == '0) && (ch_r == '0), "counters did not wrap at end of frame")

endmodule

>>> tb/sv/bb3_blur_checker.sv
// Scoreboard for the 3x3 box blur: predicts every result from the accepted beats and compares.
module bb3_blur_checker import bb3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bb3_in_if           in_mon,
  bb3_out_if          out_mon,
  bb3_cfg_if          cfg_mon,
  output int unsigned mismatch_count,
  output int unsigned results_due
);

  localparam int LINE_DEPTH  = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;
  localparam int MAX_REPORTS = 10;

  logic [PIX_W-1:0]      line_older [LINE_DEPTH];
  logic [PIX_W-1:0]      line_newer [LINE_DEPTH];
  logic [PIX_W-1:0]      win_hist [DEF_MAX_CHANNELS][3][2];
  int unsigned           pos_row, pos_col, pos_chan;
  logic [CFG_DATA_W-1:0] reg_width, reg_height;
  logic [NCH_W-1:0]      reg_chans;
  bb3_res_t              blur_expected[$];

  // One accepted sample: queue its blurred value if it closes an interior window.
  function automatic void blur_step(input logic [PIX_W-1:0] x);
    int unsigned      w, h, n, r, c, ch, addr, sum;
    logic [PIX_W-1:0] column [3];
    bit               last_ch, last_col, last_row;
    bb3_res_t         res;
    w = (reg_width < 3) ? 3 : (reg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : reg_width;
    h = (reg_height < 3) ? 3 : reg_height;
    n = (reg_chans < 1) ? 1 : (reg_chans > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : reg_chans;
    // counters past a shrunken limit are pulled back to the last position
    c  = (pos_col >= w) ? w - 1 : pos_col;
    ch = (pos_chan >= n) ? n - 1 : pos_chan;
    r  = (pos_row >= h) ? h - 1 : pos_row;
    addr = (c * DEF_MAX_CHANNELS + ch) % LINE_DEPTH;
    column[0] = line_older[addr];
    column[1] = line_newer[addr];
    column[2] = x;
    last_ch  = (ch >= n - 1);
    last_col = (c >= w - 1);
    last_row = (r >= h - 1);
    if (r >= 2 && c >= 2) begin
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        sum += column[k];
        sum += win_hist[ch][k][0];
        sum += win_hist[ch][k][1];
      end
      res.val  = PIX_W'(sum / 9);
      res.last = last_ch && last_col && last_row;
      blur_expected.push_back(res);
    end
    for (int k = 0; k < 3; k++) begin
      win_hist[ch][k][1] = win_hist[ch][k][0];
      win_hist[ch][k][0] = column[k];
    end
    line_older[addr] = line_newer[addr];
    line_newer[addr] = x;
    if (!last_ch) begin
      pos_chan = ch + 1;
      pos_col  = c;
      pos_row  = r;
    end else begin
      pos_chan = 0;
      if (!last_col) begin
        pos_col = c + 1;
        pos_row = r;
      end else begin
        pos_col = 0;
        pos_row = last_row ? 0 : r + 1;
      end
    end
  endfunction

  always @(posedge clk) begin
    bb3_res_t want;
    if (!rst_n) begin
      reg_width  = RST_IMAGE_WIDTH;
      reg_height = RST_IMAGE_HEIGHT;
      reg_chans  = RST_CHANNEL_COUNT;
      pos_row    = 0;
      pos_col    = 0;
      pos_chan   = 0;
      blur_expected.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_IMAGE_WIDTH:   reg_width  = cfg_mon.data;
          REG_IMAGE_HEIGHT:  reg_height = cfg_mon.data;
          REG_CHANNEL_COUNT: reg_chans  = cfg_mon.data[NCH_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) blur_step(in_mon.pixel_sample);
      if (out_mon.valid && out_mon.ready) begin
        if (blur_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected result beat val %0d last %0b", $time,
                     out_mon.blurred_sample, out_mon.frame_last);
        end else begin
          want = blur_expected.pop_front();
          if (out_mon.blurred_sample !== want.val || out_mon.frame_last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: result mismatch: expected val %0d last %0b, got val %0d last %0b",
                       $time, want.val, want.last, out_mon.blurred_sample,
                       out_mon.frame_last);
          end
        end
      end
    end
    results_due = blur_expected.size();
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the box blur testbench: clock, reset, stimulus, handshake idling and the verdict.
module testbench;
  import bb3_pkg::*;

  // Generous: about 1.5k beats, each with a full sender gap and a full receiver stall,
  // taken many times over.
  localparam int unsigned CYCLE_LIMIT    = 400_000;
  // Pipeline is three deep; border beats produce nothing, so give it a few more.
  localparam int          SETTLE_CYCLES  = 8;
  localparam int unsigned RANDOM_SAMPLES = 600;
  // Start of the first row of the widest frame; must stay above 3 and below the width.
  localparam int unsigned WIDE_SAMPLES   = 200;

  // Pixel content flavors for a frame.
  typedef enum int {MIX_UNIFORM, MIX_RAILS, MIX_BRIGHT} mix_e;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned mismatch_count, results_due;
  bit          src_calm, sink_calm;     // no-idle stretches on either side
  int unsigned cur_width, cur_height, cur_chans;  // shadow of the written registers

  bb3_in_if  in_ch();
  bb3_out_if out_ch();
  bb3_cfg_if cfg_ch();

  box_blur_3x3_stream u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  bb3_blur_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_mon        (cfg_ch),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Beats in one whole frame under the current (clamped) settings.
  function automatic int unsigned frame_samples();
    int unsigned w, h, n;
    w = (cur_width < 3) ? 3 : (cur_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cur_width;
    h = (cur_height < 3) ? 3 : cur_height;
    n = (cur_chans < 1) ? 1 : (cur_chans > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : cur_chans;
    return w * h * n;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input mix_e mix);
    case (mix)
      MIX_RAILS:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      MIX_BRIGHT: return PIX_W'(236 + $urandom_range(0, 19));
      default:    return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Config beat; only issued while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk) cfg_ch.valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:   cur_width  = value;
      REG_IMAGE_HEIGHT:  cur_height = value;
      REG_CHANNEL_COUNT: cur_chans  = value[NCH_W-1:0];
      default: ;
    endcase
  endtask

  // One input beat after a random gap. valid stays high between back-to-back beats,
  // so it is never lowered and raised in the same step.
  task automatic send_sample(input logic [PIX_W-1:0] value);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.pixel_sample <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_samples(input int unsigned count, input mix_e mix);
    repeat (count) send_sample(pick_pixel(mix));
  endtask

  // Stop sending, wait for every predicted result, then let the pipe drain.
  task automatic settle();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: after each accepted beat, hold ready low for a random stall.
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk) out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        stall = sink_calm ? 0 : $urandom_range(0, 11);
        if (stall != 0) begin
          @(negedge clk) out_ch.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
          @(negedge clk) out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent, n;
    mix_e        mix;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.pixel_sample = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_IMAGE_WIDTH;
    cfg_ch.data        = '0;
    src_calm           = 1'b0;
    sink_calm          = 1'b0;
    cur_width          = RST_IMAGE_WIDTH;
    cur_height         = RST_IMAGE_HEIGHT;
    cur_chans          = RST_CHANNEL_COUNT;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Smallest frame, one channel: exactly one interior result per frame, flagged last.
    write_reg(REG_IMAGE_WIDTH, 12'd3);
    write_reg(REG_IMAGE_HEIGHT, 12'd3);
    write_reg(REG_CHANNEL_COUNT, 12'd1);
    // all-255 window: the largest sum the divider sees
    repeat (9) send_sample(8'hFF);
    settle();
    // eight zeros and an 8: the mean truncates down to 0
    repeat (8) send_sample(8'h00);
    send_sample(8'd8);
    settle();

    // Register change mid-frame. A full 8x6x3 frame first writes both line stores at
    // every address the shrunken frame reads afterwards.
    write_reg(REG_IMAGE_WIDTH, 12'd8);
    write_reg(REG_IMAGE_HEIGHT, 12'd6);
    write_reg(REG_CHANNEL_COUNT, 12'd3);
    send_samples(frame_samples(), MIX_UNIFORM);
    settle();
    // stop at row 2, column 6, channel 0 and wait for the block to go quiet
    send_samples(2 * 8 * 3 + 6 * 3, MIX_UNIFORM);
    settle();
    write_reg(REG_IMAGE_WIDTH, 12'd5);
    write_reg(REG_CHANNEL_COUNT, 12'd2);
    // column 6 is now past the width: row 2 closes after one more pixel (two channels),
    // then rows 3..5 at the new width finish the frame
    send_samples(2 + 3 * 5 * 2, MIX_UNIFORM);
    settle();

    // Random frames: mostly small legal sizes, some out-of-range register values
    // that the block must clamp. Frames always complete before the next write.
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      settle();
      src_calm  = ($urandom_range(0, 4) == 0);
      sink_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, 2)));
          1:       write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(12, 24)));
          default: write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(3, 11)));
        endcase
      end
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 7) == 0)
          write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 2)));
        else
          write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(3, 7)));
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0:       write_reg(REG_CHANNEL_COUNT, 12'd0);
          1:       write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(5, 7)));
          default: write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(1, 4)));
        endcase
      end
      n   = frame_samples();
      mix = mix_e'($urandom_range(0, 2));
      send_samples(n, mix);
      sent += n;
    end
    settle();
    src_calm  = 1'b0;
    sink_calm = 1'b0;

    // Widest frame: width all ones clamps to the maximum, zero height and zero
    // channels clamp to their minimums. Only the start of row 0 is sent; the frame
    // is then shrunk to 3x3, so the column is past the width, the next pixel closes
    // row 0 and two more rows finish the frame with one flagged result.
    write_reg(REG_IMAGE_WIDTH, 12'hFFF);
    write_reg(REG_IMAGE_HEIGHT, 12'h000);
    write_reg(REG_CHANNEL_COUNT, 12'd0);
    send_samples(WIDE_SAMPLES, MIX_UNIFORM);
    settle();
    write_reg(REG_IMAGE_WIDTH, 12'd3);
    write_reg(REG_IMAGE_HEIGHT, 12'd3);
    send_samples(1 + 2 * 3, MIX_UNIFORM);
    settle();

    // Tallest frame, narrow: only its top rows are sent, the run ends mid-frame.
    write_reg(REG_IMAGE_WIDTH, 12'd3);
    write_reg(REG_IMAGE_HEIGHT, 12'hFFF);
    write_reg(REG_CHANNEL_COUNT, 12'd1);
    send_samples(400, MIX_UNIFORM);
    settle();

    if (mismatch_count == 0 && results_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bb3_pkg.sv
rtl/bb3_if.sv
rtl/bb3_ram.sv
rtl/box_blur_3x3_stream.sv
tb/sv/bb3_blur_checker.sv
tb/sv/testbench.sv
